// ----- sv/qbpd_pkg.sv -----
package qbpd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_STEP_BITS  = 2'd0;
    localparam logic [1:0] CFG_BLOCK_COLS = 2'd1;
    localparam logic [1:0] CFG_BLOCK_ROWS = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Endpoint field masks and control word width
    localparam logic [4:0] MASK5     = 5'h1F;
    localparam logic [5:0] MASK6     = 6'h3F;
    localparam int         CTRL_BITS = 16;

    // Step index width limits
    localparam logic [3:0] Q_MIN = 4'd1;
    localparam logic [3:0] Q_MAX = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PIX
    } t_state;

    typedef enum logic [2:0] {
        PH_LO0,
        PH_HI0,
        PH_LO1,
        PH_HI1,
        PH_IDX
    } t_phase;

    typedef enum logic [1:0] {
        DS_CH0,
        DS_CH1,
        DS_CH2,
        DS_PC
    } t_div_sel;

    typedef logic [2:0][7:0] t_chans;

    typedef struct packed {
        logic     ld_lo;
        logic     ld_min;
        logic     ld_max;
        logic     ld_idx;
        logic     div_start;
        logic     div_take;
        t_div_sel div_sel;
        logic     pix_emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic pix_last;
        logic pix_break;
    } t_stat;

    // RGB565 word to three widened channels
    function automatic t_chans split565(input logic [CTRL_BITS-1:0] w);
        t_chans c;
        c[0] = {w[4:0] & MASK5, 3'b000};
        c[1] = {w[10:5] & MASK6, 2'b00};
        c[2] = {w[15:11] & MASK5, 3'b000};
        return c;
    endfunction

endpackage

// ----- sv/qbpd_div.sv -----
module qbpd_div #(
    parameter int DW  = 12,
    parameter int DVW = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic           o_done,
    output logic [DW-1:0]  o_quo,
    output logic [DVW-1:0] o_rem
);

    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic            r_done;
    logic [DVW-1:0]  r_rem;
    logic [DW-1:0]   r_quo;
    logic [DVW-1:0]  r_dvs;

    logic [DVW:0]    w_sh;
    logic [DVW:0]    w_diff;
    logic            w_ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        w_sh   = {r_rem, r_quo[DW-1]};
        w_ge   = (w_sh >= {1'b0, r_dvs});
        w_diff = w_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? DVW'(w_diff) : DVW'(w_sh);
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ----- sv/qbpd_datapath.sv -----
module qbpd_datapath #(
    parameter int MAX_BLOCK_DIM = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [7:0]                            i_byte,
    input  logic [3:0]                            i_q,
    input  logic [$clog2(MAX_BLOCK_DIM+1)-1:0]    i_cols,
    input  logic [$clog2(MAX_BLOCK_DIM+1)-1:0]    i_rows,
    input  qbpd_pkg::t_cmd                        i_cmd,
    output qbpd_pkg::t_stat                       o_stat,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic [7:0]                            o_chan0,
    output logic [7:0]                            o_chan1,
    output logic [7:0]                            o_chan2,
    output logic [5:0]                            o_pix_col,
    output logic [5:0]                            o_pix_row,
    output logic                                  o_block_done
);

    localparam int DVW  = $clog2(MAX_BLOCK_DIM + 1);
    localparam int PCW  = $clog2(MAX_BLOCK_DIM * MAX_BLOCK_DIM);
    localparam int DW   = (PCW > 8) ? PCW : 8;
    localparam int DVSW = (DVW > 8) ? DVW : 8;
    localparam int TW   = 2 * DVW;

    // endpoint state
    logic [7:0]           r_lo;
    logic [2:0][7:0]      r_min;
    logic [2:0][7:0]      r_mag;
    logic [2:0]           r_neg;
    logic signed [8:0]    r_sq [3];

    // pixel walk state
    logic [PCW-1:0]       r_pc;
    logic [DVW-1:0]       r_col;
    logic [PCW-1:0]       r_row;
    logic [7:0]           r_buf;

    // output register
    logic                 r_out_valid;
    logic [7:0]           r_chan [3];
    logic [5:0]           r_pix_col;
    logic [5:0]           r_pix_row;
    logic                 r_block_done;

    qbpd_pkg::t_chans     w_word;
    logic [2:0][9:0]      w_delta;
    logic [7:0]           w_mask;
    logic [7:0]           w_idx;
    logic [7:0]           w_chan [3];
    logic signed [17:0]   w_prod [3];
    logic [TW-1:0]        w_pc_nx;
    logic [TW-1:0]        w_total;
    logic                 w_last;
    logic [2:0]           w_pn3;
    logic [5:0]           w_brk_prod;
    logic [DVW:0]         w_col_nx;
    logic                 w_col_wrap;
    logic [DW-1:0]        w_dividend;
    logic [DVSW-1:0]      w_divisor;
    logic                 w_div_done;
    logic [DW-1:0]        w_quo;
    logic [DVSW-1:0]      w_rem;
    logic [8:0]           w_qmag;

    qbpd_div #(
        .DW  (DW),
        .DVW (DVSW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    always_comb begin
        w_word = qbpd_pkg::split565({i_byte, r_lo});
        for (int i = 0; i < 3; i++) begin
            w_delta[i] = {2'b00, w_word[i]} - {2'b00, r_min[i]};
        end
        w_mask = 8'((9'd1 << i_q) - 9'd1);
        w_idx  = r_buf & w_mask;
        for (int i = 0; i < 3; i++) begin
            w_prod[i] = r_sq[i] * $signed({1'b0, w_idx});
            w_chan[i] = r_min[i] + w_prod[i][7:0];
        end

        w_pc_nx = TW'(r_pc) + TW'(1);
        w_total = TW'(i_cols) * TW'(i_rows);
        w_last  = (w_pc_nx >= w_total);

        // next pixel starts a byte when q * (pc + 1) is a multiple of 8
        w_pn3      = 3'(w_pc_nx);
        w_brk_prod = {3'b000, i_q[2:0]} * {3'b000, w_pn3};

        w_col_nx   = {1'b0, r_col} + (DVW+1)'(1);
        w_col_wrap = (w_col_nx >= {1'b0, i_cols});

        case (i_cmd.div_sel)
            qbpd_pkg::DS_CH0: w_dividend = DW'(r_mag[0]);
            qbpd_pkg::DS_CH1: w_dividend = DW'(r_mag[1]);
            qbpd_pkg::DS_CH2: w_dividend = DW'(r_mag[2]);
            default:          w_dividend = DW'(r_pc);
        endcase
        w_divisor = (i_cmd.div_sel == qbpd_pkg::DS_PC) ? DVSW'(i_cols) : DVSW'(w_mask);
        w_qmag    = {1'b0, w_quo[7:0]};
    end

    // endpoint registers and step quotients
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_lo) begin
            r_lo <= i_byte;
        end
        if (i_cmd.ld_min) begin
            r_min <= w_word;
        end
        if (i_cmd.ld_max) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= w_delta[i][9];
                r_mag[i] <= w_delta[i][9] ? 8'(-w_delta[i]) : w_delta[i][7:0];
            end
        end
        if (i_cmd.div_take) begin
            case (i_cmd.div_sel)
                qbpd_pkg::DS_CH0: r_sq[0] <= r_neg[0] ? -$signed(w_qmag) : $signed(w_qmag);
                qbpd_pkg::DS_CH1: r_sq[1] <= r_neg[1] ? -$signed(w_qmag) : $signed(w_qmag);
                qbpd_pkg::DS_CH2: r_sq[2] <= r_neg[2] ? -$signed(w_qmag) : $signed(w_qmag);
                default: ;
            endcase
        end
    end

    // pixel counter, coordinates, index byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= '0;
            r_col <= '0;
            r_row <= '0;
            r_buf <= '0;
        end else begin
            if (i_cmd.ld_idx) begin
                r_buf <= i_byte;
            end
            if (i_cmd.div_take && i_cmd.div_sel == qbpd_pkg::DS_PC) begin
                r_row <= PCW'(w_quo);
                r_col <= DVW'(w_rem);
            end
            if (i_cmd.pix_emit) begin
                if (w_last) begin
                    r_pc  <= '0;
                    r_col <= '0;
                    r_row <= '0;
                    r_buf <= '0;
                end else begin
                    r_pc  <= r_pc + PCW'(1);
                    r_buf <= 8'({1'b0, r_buf} >> i_q);
                    if (w_col_wrap) begin
                        r_col <= '0;
                        r_row <= r_row + PCW'(1);
                    end else begin
                        r_col <= DVW'(w_col_nx);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pix_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_emit) begin
            for (int i = 0; i < 3; i++) begin
                r_chan[i] <= w_chan[i];
            end
            r_pix_col    <= 6'(r_col);
            r_pix_row    <= 6'(r_row);
            r_block_done <= w_last;
        end
    end

    assign o_stat.div_done  = w_div_done;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.pix_last  = w_last;
    assign o_stat.pix_break = (w_brk_prod[2:0] == 3'd0);

    assign o_out_valid  = r_out_valid;
    assign o_chan0      = r_chan[0];
    assign o_chan1      = r_chan[1];
    assign o_chan2      = r_chan[2];
    assign o_pix_col    = r_pix_col;
    assign o_pix_row    = r_pix_row;
    assign o_block_done = r_block_done;

endmodule

// ----- sv/qbpd_ctrl.sv -----
module qbpd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_cols_wr,
    input  qbpd_pkg::t_stat  i_stat,
    output qbpd_pkg::t_cmd   o_cmd
);

    qbpd_pkg::t_state   r_state, n_state;
    qbpd_pkg::t_phase   r_phase, n_phase;
    qbpd_pkg::t_div_sel r_sel, n_sel;
    logic               r_dirty, n_dirty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qbpd_pkg::ST_IDLE;
            r_phase <= qbpd_pkg::PH_LO0;
            r_sel   <= qbpd_pkg::DS_CH0;
            r_dirty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_sel   <= n_sel;
            r_dirty <= n_dirty;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_sel         = r_sel;
        n_dirty       = r_dirty || i_cols_wr;
        o_cmd         = '0;
        o_cmd.div_sel = r_sel;
        o_in_ready    = (r_state == qbpd_pkg::ST_IDLE);

        unique case (r_state)
            qbpd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (r_phase)
                        qbpd_pkg::PH_LO0: begin
                            o_cmd.ld_lo = 1'b1;
                            n_phase     = qbpd_pkg::PH_HI0;
                        end
                        qbpd_pkg::PH_HI0: begin
                            o_cmd.ld_min = 1'b1;
                            n_phase      = qbpd_pkg::PH_LO1;
                        end
                        qbpd_pkg::PH_LO1: begin
                            o_cmd.ld_lo = 1'b1;
                            n_phase     = qbpd_pkg::PH_HI1;
                        end
                        qbpd_pkg::PH_HI1: begin
                            o_cmd.ld_max = 1'b1;
                            n_phase      = qbpd_pkg::PH_IDX;
                            n_sel        = qbpd_pkg::DS_CH0;
                            n_state      = qbpd_pkg::ST_DIV_START;
                        end
                        qbpd_pkg::PH_IDX: begin
                            o_cmd.ld_idx = 1'b1;
                            if (n_dirty) begin
                                // coordinates must be rebuilt from the pixel count
                                n_sel   = qbpd_pkg::DS_PC;
                                n_state = qbpd_pkg::ST_DIV_START;
                            end else begin
                                n_state = qbpd_pkg::ST_PIX;
                            end
                        end
                        default: begin
                            n_phase = qbpd_pkg::PH_LO0;
                        end
                    endcase
                end
            end
            qbpd_pkg::ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
                if (r_sel == qbpd_pkg::DS_PC) begin
                    n_dirty = i_cols_wr;
                end
                n_state = qbpd_pkg::ST_DIV_WAIT;
            end
            qbpd_pkg::ST_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.div_take = 1'b1;
                    unique case (r_sel)
                        qbpd_pkg::DS_CH0: begin
                            n_sel   = qbpd_pkg::DS_CH1;
                            n_state = qbpd_pkg::ST_DIV_START;
                        end
                        qbpd_pkg::DS_CH1: begin
                            n_sel   = qbpd_pkg::DS_CH2;
                            n_state = qbpd_pkg::ST_DIV_START;
                        end
                        qbpd_pkg::DS_CH2: begin
                            n_state = qbpd_pkg::ST_IDLE;
                        end
                        default: begin
                            n_state = qbpd_pkg::ST_PIX;
                        end
                    endcase
                end
            end
            qbpd_pkg::ST_PIX: begin
                if (i_stat.out_free) begin
                    o_cmd.pix_emit = 1'b1;
                    if (i_stat.pix_last) begin
                        n_phase = qbpd_pkg::PH_LO0;
                        n_dirty = i_cols_wr;
                        n_state = qbpd_pkg::ST_IDLE;
                    end else if (i_stat.pix_break) begin
                        n_state = qbpd_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = qbpd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/quantized_block_pixel_decoder_core.sv -----
// Block truncation style pixel decoder with a programmable step index width.
//
// Input channel (i_in_valid / o_in_ready / i_stream_byte): one byte per transfer.
// Each block is four endpoint bytes (min then max, little-endian RGB565)
// followed by packed step index bytes, LSB first.
// Output channel (o_out_valid / i_out_ready): one pixel per transfer, in raster
// order, with o_block_done set on the last pixel of the block.
// Config port (i_cfg_we / i_cfg_index / i_cfg_data): step_bits, block_cols,
// block_rows; write only between transfers, never while pixels are pending.
//
// Sequence: endpoint bytes 0..2 load the endpoint registers. Byte 3 runs three
// serial divisions, one per channel, on the shared divider, whose dividend is
// DW = max(8, clog2(MAX_BLOCK_DIM^2)) bits wide.
// An index byte yields 1..8 pixels; after the transfer the controller enters
// its pixel state and each pixel is then registered in the output register.
// After any block_cols write, the next index byte first runs one divider pass
// to rebuild the column and row from the pixel count.
// Reset (synchronous, active low) returns to the first endpoint byte with
// defaults step_bits=2, 4x4 block. A stalled receiver holds the output
// register; pixel generation waits and o_in_ready stays low until done.
module quantized_block_pixel_decoder_core #(
    parameter int MAX_BLOCK_DIM = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // byte input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_stream_byte,
    // pixel output
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [7:0]                          o_chan0,
    output logic [7:0]                          o_chan1,
    output logic [7:0]                          o_chan2,
    output logic [5:0]                          o_pix_col,
    output logic [5:0]                          o_pix_row,
    output logic                                o_block_done,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [qbpd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [qbpd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int DVW = $clog2(MAX_BLOCK_DIM + 1);
    localparam int CLW = (DVW > qbpd_pkg::CFG_DATA_W) ? DVW : qbpd_pkg::CFG_DATA_W;

    // raw register values, clamped below before use
    logic [3:0]                        r_step_bits;
    logic [qbpd_pkg::CFG_DATA_W-1:0]   r_block_cols;
    logic [qbpd_pkg::CFG_DATA_W-1:0]   r_block_rows;

    logic [3:0]      w_q;
    logic [CLW-1:0]  w_cols_ext;
    logic [CLW-1:0]  w_rows_ext;
    logic [DVW-1:0]  w_cols;
    logic [DVW-1:0]  w_rows;
    logic            w_cols_wr;

    qbpd_pkg::t_cmd  w_cmd;
    qbpd_pkg::t_stat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_bits  <= 4'd2;
            r_block_cols <= qbpd_pkg::CFG_DATA_W'(4);
            r_block_rows <= qbpd_pkg::CFG_DATA_W'(4);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                qbpd_pkg::CFG_STEP_BITS:  r_step_bits  <= i_cfg_data[3:0];
                qbpd_pkg::CFG_BLOCK_COLS: r_block_cols <= i_cfg_data;
                qbpd_pkg::CFG_BLOCK_ROWS: r_block_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a width change invalidates the running column/row pair
    assign w_cols_wr = i_cfg_we && (i_cfg_index == qbpd_pkg::CFG_BLOCK_COLS);

    always_comb begin
        // step bits: 0 acts as 1, above 8 acts as 8
        if (r_step_bits < qbpd_pkg::Q_MIN) begin
            w_q = qbpd_pkg::Q_MIN;
        end else if (r_step_bits > qbpd_pkg::Q_MAX) begin
            w_q = qbpd_pkg::Q_MAX;
        end else begin
            w_q = r_step_bits;
        end

        // block dimensions saturate to 2..MAX_BLOCK_DIM
        w_cols_ext = CLW'(r_block_cols);
        w_rows_ext = CLW'(r_block_rows);
        if (w_cols_ext < CLW'(2)) begin
            w_cols = DVW'(2);
        end else if (w_cols_ext > CLW'(MAX_BLOCK_DIM)) begin
            w_cols = DVW'(MAX_BLOCK_DIM);
        end else begin
            w_cols = DVW'(w_cols_ext);
        end
        if (w_rows_ext < CLW'(2)) begin
            w_rows = DVW'(2);
        end else if (w_rows_ext > CLW'(MAX_BLOCK_DIM)) begin
            w_rows = DVW'(MAX_BLOCK_DIM);
        end else begin
            w_rows = DVW'(w_rows_ext);
        end
    end

    qbpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cols_wr  (w_cols_wr),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    qbpd_datapath #(
        .MAX_BLOCK_DIM (MAX_BLOCK_DIM)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_stream_byte),
        .i_q          (w_q),
        .i_cols       (w_cols),
        .i_rows       (w_rows),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_chan0      (o_chan0),
        .o_chan1      (o_chan1),
        .o_chan2      (o_chan2),
        .o_pix_col    (o_pix_col),
        .o_pix_row    (o_pix_row),
        .o_block_done (o_block_done)
    );

endmodule

// ----- bench/quantized_block_pixel_decoder_core_tb.sv -----
`timescale 1ns / 100ps

module quantized_block_pixel_decoder_core_tb;

    localparam int CLK_HALF      = 6;     // 12 ns period
    localparam int SETTLE_CYCLES = 64;    // header divisions plus a pixel burst
    localparam int STALL_LIMIT   = 5000;  // cycles with no transfer before giving up
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off for back-pressure
    localparam int RANDOM_ITEMS  = 260;

    // Index 3 decodes to no register; writes there must be ignored.
    localparam logic [qbpd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // What happens partway through a block's index bytes.
    typedef enum {BRK_NONE, BRK_PAUSE, BRK_RECONFIG} t_break;

    typedef struct packed {
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
        logic [5:0] col;
        logic [5:0] row;
        logic       done;
    } t_pixel;

    // ------------------------------------------------------------------
    // Decoder mirror plus queue of pixels still owed by the block.
    // ------------------------------------------------------------------
    class t_pixel_scoreboard;
        logic [3:0]        step_bits_r;
        logic [6:0]        cols_r;
        logic [6:0]        rows_r;
        qbpd_pkg::t_phase  phase;
        logic [7:0]        low_byte;
        int                min_ch[3];
        int                step_q[3];
        int unsigned       pix_cnt;
        logic [7:0]        idx_buf;
        t_pixel            pixels_due[$];
        int                errors;
        int                pixels_seen;
        int                blocks_seen;

        function new();
            step_bits_r = 4'd2;
            cols_r      = 7'd4;
            rows_r      = 7'd4;
            phase       = qbpd_pkg::PH_LO0;
            low_byte    = '0;
            pix_cnt     = 0;
            idx_buf     = '0;
            foreach (min_ch[i]) begin
                min_ch[i] = 0;
                step_q[i] = 0;
            end
            errors      = 0;
            pixels_seen = 0;
            blocks_seen = 0;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void widen(input logic [15:0] w, output int ch[3]);
            ch[0] = int'(w[4:0]) * 8;
            ch[1] = int'(w[10:5]) * 4;
            ch[2] = int'(w[15:11]) * 8;
        endfunction

        function void write_reg(logic [qbpd_pkg::CFG_IDX_W-1:0] sel,
                                logic [qbpd_pkg::CFG_DATA_W-1:0] val);
            case (sel)
                qbpd_pkg::CFG_STEP_BITS:  step_bits_r = val[3:0];
                qbpd_pkg::CFG_BLOCK_COLS: cols_r      = val;
                qbpd_pkg::CFG_BLOCK_ROWS: rows_r      = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction

        // Index bytes still needed to close the block, starting at pixel from_pix.
        function int index_bytes_left(int unsigned from_pix);
            int unsigned q;
            int unsigned total;
            int unsigned p;
            int          n;
            q     = clamp(step_bits_r, 1, 8);
            total = clamp(cols_r, 2, 64) * clamp(rows_r, 2, 64);
            p     = from_pix;
            n     = 1;
            while (p + 1 < total) begin
                p++;
                if (((q * p) & 7) == 0) n++;
            end
            return n;
        endfunction

        // One accepted stream byte: advance the header or unpack pixels.
        function void decode_byte(logic [7:0] b);
            int unsigned q;
            int unsigned cols;
            int unsigned total;
            logic [7:0]  mask;
            logic [7:0]  idx;
            int          max_ch[3];
            int          v;
            int          n;
            bit          running;
            t_pixel      px;
            q     = clamp(step_bits_r, 1, 8);
            mask  = 8'((16'd1 << q) - 16'd1);
            cols  = clamp(cols_r, 2, 64);
            total = cols * clamp(rows_r, 2, 64);
            case (phase)
                qbpd_pkg::PH_LO0: begin
                    low_byte = b;
                    phase    = qbpd_pkg::PH_HI0;
                end
                qbpd_pkg::PH_LO1: begin
                    low_byte = b;
                    phase    = qbpd_pkg::PH_HI1;
                end
                qbpd_pkg::PH_HI0: begin
                    widen({b, low_byte}, min_ch);
                    phase = qbpd_pkg::PH_LO1;
                end
                qbpd_pkg::PH_HI1: begin
                    widen({b, low_byte}, max_ch);
                    // signed step, truncated toward zero
                    foreach (step_q[i]) step_q[i] = (max_ch[i] - min_ch[i]) / int'(mask);
                    phase = qbpd_pkg::PH_IDX;
                end
                default: begin
                    idx_buf = b;
                    n       = 0;
                    running = 1'b1;
                    while (running && n < 8) begin
                        idx     = idx_buf & mask;
                        px.done = (pix_cnt + 1 >= total);
                        idx_buf = idx_buf >> q;
                        v = min_ch[0] + step_q[0] * int'(idx);
                        px.chan0 = v[7:0];
                        v = min_ch[1] + step_q[1] * int'(idx);
                        px.chan1 = v[7:0];
                        v = min_ch[2] + step_q[2] * int'(idx);
                        px.chan2 = v[7:0];
                        px.col = 6'(pix_cnt % cols);
                        px.row = 6'(pix_cnt / cols);
                        pixels_due.push_back(px);
                        n++;
                        if (px.done) begin
                            phase   = qbpd_pkg::PH_LO0;
                            pix_cnt = 0;
                            idx_buf = '0;
                            blocks_seen++;
                            running = 1'b0;
                        end else begin
                            pix_cnt++;
                            if (((q * pix_cnt) & 7) == 0) running = 1'b0;
                        end
                    end
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("pixel %0d %s: got 0x%0h, want 0x%0h",
                                 pixels_seen, name, got, want));
        endtask

        task check_pixel(t_pixel got);
            t_pixel want;
            if (pixels_due.size() == 0) begin
                report($sformatf("pixel %0d with nothing expected (col %0d row %0d)",
                                 pixels_seen, got.col, got.row));
            end else begin
                want = pixels_due.pop_front();
                compare_field("chan0", got.chan0, want.chan0);
                compare_field("chan1", got.chan1, want.chan1);
                compare_field("chan2", got.chan2, want.chan2);
                compare_field("pix_col", got.col, want.col);
                compare_field("pix_row", got.row, want.row);
                compare_field("block_done", got.done, want.done);
            end
            pixels_seen++;
        endtask
    endclass

    // ------------------------------------------------------------------
    // Block under test. All inputs start at known values.
    // ------------------------------------------------------------------
    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_in_valid    = 1'b0;
    logic [7:0]                      i_stream_byte = '0;
    logic                            i_out_ready   = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    logic [qbpd_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [qbpd_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                            o_in_ready;
    logic                            o_out_valid;
    logic [7:0]                      o_chan0;
    logic [7:0]                      o_chan1;
    logic [7:0]                      o_chan2;
    logic [5:0]                      o_pix_col;
    logic [5:0]                      o_pix_row;
    logic                            o_block_done;

    quantized_block_pixel_decoder_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_stream_byte (i_stream_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_chan0       (o_chan0),
        .o_chan1       (o_chan1),
        .o_chan2       (o_chan2),
        .o_pix_col     (o_pix_col),
        .o_pix_row     (o_pix_row),
        .o_block_done  (o_block_done),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    t_pixel_scoreboard sb = new();

    int send_idle_pct  = 0;   // chance per cycle that the sender holds off
    int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
    int hold_requests  = 0;   // bumped by the stimulus to start a hold-off
    int hold_served    = 0;   // hold-off requests already started
    int hold_left      = 0;   // remaining cycles of a forced receiver hold-off
    int bytes_sent     = 0;
    int cfg_writes     = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Receiver: random stalls, overridden by a forced hold-off.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hold-off countdown lives in its own process.
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: every transfer sampled at the edge it happens on.
    // Pixels are checked before the byte of the same edge is decoded; a
    // byte never produces a pixel in the cycle it is taken, so the order
    // of the queue is unaffected.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_pixel('{chan0: o_chan0, chan1: o_chan1, chan2: o_chan2,
                                 col: o_pix_col, row: o_pix_row, done: o_block_done});
            end
            if (i_in_valid && o_in_ready) begin
                sb.decode_byte(i_stream_byte);
            end
        end
    end

    // Watchdog: ends the run after too long without any transfer.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles, %0d pixels outstanding",
                 STALL_LIMIT, sb.pending());
        $display("quantized_block_pixel_decoder_core_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers. Every task is entered just after a rising edge.
    // ------------------------------------------------------------------

    // Offer one byte, after random idle cycles, and hold it until the transfer.
    task send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_stream_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    // Stop offering and wait for every owed pixel; then let the block settle.
    // The first edge lets the monitor decode the byte taken at the last one.
    task drain(input int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task write_reg(input logic [qbpd_pkg::CFG_IDX_W-1:0] sel,
                   input logic [qbpd_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.write_reg(sel, val);
        cfg_writes++;
    endtask

    task set_config(input logic [qbpd_pkg::CFG_DATA_W-1:0] steps,
                    input logic [qbpd_pkg::CFG_DATA_W-1:0] cols,
                    input logic [qbpd_pkg::CFG_DATA_W-1:0] rows);
        drain(SETTLE_CYCLES);
        write_reg(qbpd_pkg::CFG_STEP_BITS, steps);
        write_reg(qbpd_pkg::CFG_BLOCK_COLS, cols);
        write_reg(qbpd_pkg::CFG_BLOCK_ROWS, rows);
        i_cfg_we <= 1'b0;
    endtask

    task set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // One whole block with random endpoints and indices. Unless kind is BRK_NONE, after
    // break_at index bytes the sender waits for every pixel, and for BRK_RECONFIG then
    // rewrites one register mid-block; the remaining byte count follows the new settings.
    task send_block(input int break_at, input t_break kind,
                    input logic [qbpd_pkg::CFG_IDX_W-1:0] sel,
                    input logic [qbpd_pkg::CFG_DATA_W-1:0] val);
        int left;
        int sent;
        repeat (4) send_byte(8'($urandom_range(255)));
        left = sb.index_bytes_left(0);
        sent = 0;
        while (left > 0) begin
            if (sent == break_at && kind == BRK_PAUSE) begin
                drain(0);
            end else if (sent == break_at && kind == BRK_RECONFIG) begin
                drain(SETTLE_CYCLES);
                write_reg(sel, val);
                i_cfg_we <= 1'b0;
                left = sb.index_bytes_left(sb.pix_cnt);
            end
            send_byte(8'($urandom_range(255)));
            sent++;
            left--;
        end
    endtask

    // Random block: half plain, otherwise with a pause or a register change.
    task random_block();
        t_break                          kind;
        logic [qbpd_pkg::CFG_IDX_W-1:0]  sel;
        logic [qbpd_pkg::CFG_DATA_W-1:0] val;
        int                              at;
        case ($urandom_range(3))
            0:       kind = BRK_PAUSE;
            1:       kind = BRK_RECONFIG;
            default: kind = BRK_NONE;
        endcase
        case ($urandom_range(2))
            0:       sel = qbpd_pkg::CFG_STEP_BITS;
            1:       sel = qbpd_pkg::CFG_BLOCK_COLS;
            default: sel = qbpd_pkg::CFG_BLOCK_ROWS;
        endcase
        val = (sel == qbpd_pkg::CFG_STEP_BITS) ? 7'($urandom_range(127))
                                               : 7'($urandom_range(8));
        at  = $urandom_range(sb.index_bytes_left(0) - 1);
        send_block(at, kind, sel, val);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int random_start;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: defaults (2-bit steps, 4x4), full-range endpoints,
        // all-zero, all-one and mixed index bytes.
        send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF); send_byte(8'hFF);
        send_byte(8'hFF); send_byte(8'h00); send_byte(8'hE4); send_byte(8'h1B);

        // Step width 0 acts as 1, tiny dims saturate to 2x2; min above max
        // gives negative steps. The block ends partway through its only byte.
        set_config(7'd0, 7'd0, 7'd1);
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h05);

        // Step width 15 acts as 8; then the width changes mid-block and the
        // last byte yields the rest of the block at 3 bits per index.
        set_config(7'd15, 7'd2, 7'd2);
        send_byte(8'h34); send_byte(8'h12); send_byte(8'hE1); send_byte(8'hF0);
        send_byte(8'h80);
        drain(SETTLE_CYCLES);
        write_reg(qbpd_pkg::CFG_STEP_BITS, 7'd3);
        i_cfg_we <= 1'b0;
        send_byte(8'h7F);

        random_start = bytes_sent;

        // No idling, odd step width: eight pixels per byte.
        set_config(7'd3, 7'd5, 7'd3);
        repeat (5) send_block(-1, BRK_NONE, qbpd_pkg::CFG_STEP_BITS, '0);

        // Sender idle most cycles, one pixel per byte.
        set_idling(80, 0);
        set_config(7'd8, 7'd2, 7'd3);
        repeat (3) send_block(-1, BRK_NONE, qbpd_pkg::CFG_STEP_BITS, '0);

        // Receiver stalling most cycles; columns saturate to 64.
        set_idling(0, 80);
        set_config(7'd1, 7'd127, 7'd2);
        repeat (2) send_block(-1, BRK_NONE, qbpd_pkg::CFG_STEP_BITS, '0);

        // Both sides idling; rows saturate to 64. Unused index written too.
        set_idling(24, 24);
        set_config(7'd5, 7'd2, 7'd127);
        write_reg(CFG_UNUSED, 7'($urandom_range(127)));
        i_cfg_we <= 1'b0;
        repeat (2) send_block(-1, BRK_NONE, qbpd_pkg::CFG_STEP_BITS, '0);

        // Back-pressure: receiver held off while the sender keeps offering,
        // then a block where the sender waits for every pixel partway through.
        set_idling(0, 0);
        set_config(7'd2, 7'd7, 7'd9);
        hold_requests <= hold_requests + 1;
        send_block(-1, BRK_NONE, qbpd_pkg::CFG_STEP_BITS, '0);
        send_block(8, BRK_PAUSE, qbpd_pkg::CFG_STEP_BITS, '0);

        // Shrinking the block below the pixel count ends it at the next pixel,
        // with a row number past 63 that wraps to six bits.
        set_idling(24, 24);
        set_config(7'd1, 7'd3, 7'd64);
        send_block(17, BRK_RECONFIG, qbpd_pkg::CFG_BLOCK_COLS, 7'd2);

        // Random settings and idling until the item budget is used.
        while (bytes_sent - random_start < RANDOM_ITEMS) begin
            case ($urandom_range(3))
                0:       set_idling(0, 0);
                1:       set_idling(80, 0);
                2:       set_idling(0, 80);
                default: set_idling(24, 24);
            endcase
            set_config(7'($urandom_range(127)), 7'($urandom_range(6)), 7'($urandom_range(6)));
            repeat ($urandom_range(1, 2)) random_block();
        end

        set_idling(0, 0);
        drain(SETTLE_CYCLES);

        $display("covered %0d bytes, %0d pixels, %0d blocks, %0d register writes",
                 bytes_sent, sb.pixels_seen, sb.blocks_seen, cfg_writes);
        $display("step widths 0..15, dims 0..127, mid-block changes, %0d mismatches",
                 sb.errors);
        if (sb.errors == 0) begin
            $display("quantized_block_pixel_decoder_core_tb: PASS");
        end else begin
            $display("quantized_block_pixel_decoder_core_tb: FAIL");
        end
        $finish;
    end

endmodule
